### rtl/rdb_pkg.sv
// Shared types and constants for the replay dependency buffer.
`timescale 1ns / 1ps

package rdb_pkg;

  // Field widths of one request.
  localparam int ID_W   = 12;
  localparam int OPC_W  = 3;
  localparam int IDX_W  = 4;
  localparam int DUSE_W = 2;
  localparam int SUSE_W = 4;

  // Number of keys compared against the buffer during one scan.
  localparam int KEYS = 4;

  // Operand counts examined; only two destinations and three sources exist as fields.
  localparam int NUM_DESTS   = 2;
  localparam int NUM_SOURCES = 3;

  // Usable-operand masks that follow from the operand counts.
  localparam logic [DUSE_W-1:0] DST_MASK = DUSE_W'((1 << NUM_DESTS) - 1);
  localparam logic [SUSE_W-1:0] SRC_MASK = SUSE_W'((((1 << NUM_SOURCES) - 1) << 1) | 1);

  // Operation codes.
  localparam logic [OPC_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OPC_W-1:0] OP_CHECK = 3'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OPC_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OPC_W-1:0] OP_FLUSH = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic commit0;
    logic commit1;
    logic finish;
  } rdb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;
    logic scan_last;
    logic is_add;
  } rdb_status_t;

endpackage

### rtl/replay_dependency_buffer_top.sv
// Top level of the replay dependency buffer.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and must be taken then.
// Add and check walk the id store one entry per cycle through its single read
// port; check then passes a last-compare state and the finishing state, and
// add also writes up to two ids through the single write port in two commit
// states before finishing. An add while the
// overflow flag is set, an add or check of an invalid instruction, and clear,
// query, flush and unused codes go straight to the finishing state. A new
// request is taken once done shows. After reset the buffer is empty at once.
module replay_dependency_buffer_top
  import rdb_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OPC_W-1:0]  opcode,
  input  logic              instr_valid,
  input  logic [ID_W-1:0]   dst0_id,
  input  logic [ID_W-1:0]   dst1_id,
  input  logic [DUSE_W-1:0] dst_use,
  input  logic [ID_W-1:0]   pred_id,
  input  logic [ID_W-1:0]   src0_id,
  input  logic [ID_W-1:0]   src1_id,
  input  logic [ID_W-1:0]   src2_id,
  input  logic [SUSE_W-1:0] src_use,
  input  logic [IDX_W-1:0]  entry_index,
  output logic              done,
  output logic              dependent,
  output logic              entry_valid,
  output logic              buffer_empty,
  output logic              overflowed
);

  rdb_cmd_t    cmd;
  rdb_status_t status;

  // Sequencer.
  rdb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // Storage and compare datapath.
  rdb_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .instr_valid  (instr_valid),
    .dst0_id      (dst0_id),
    .dst1_id      (dst1_id),
    .dst_use      (dst_use),
    .pred_id      (pred_id),
    .src0_id      (src0_id),
    .src1_id      (src1_id),
    .src2_id      (src2_id),
    .src_use      (src_use),
    .entry_index  (entry_index),
    .cmd          (cmd),
    .status       (status),
    .done         (done),
    .dependent    (dependent),
    .entry_valid  (entry_valid),
    .buffer_empty (buffer_empty),
    .overflowed   (overflowed)
  );

endmodule

### rtl/rdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rdb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rdb_ctrl.sv
// Controller state machine that sequences scan, insert and finish steps.
`timescale 1ns / 1ps

module rdb_ctrl
  import rdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output rdb_cmd_t    cmd,
  input  rdb_status_t status
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_LAST    = 3'd2;
  localparam logic [2:0] S_COMMIT0 = 3'd3;
  localparam logic [2:0] S_COMMIT1 = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = status.needs_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = status.is_add ? S_COMMIT0 : S_FINISH;
      end
      S_COMMIT0: begin
        cmd.commit0 = 1'b1;
        state_next  = S_COMMIT1;
      end
      S_COMMIT1: begin
        cmd.commit1 = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### rtl/rdb_datapath.sv
// Datapath: request registers, id store scan, valid bits, flags and result registers.
`timescale 1ns / 1ps

module rdb_datapath
  import rdb_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [OPC_W-1:0]  opcode,
  input  logic              instr_valid,
  input  logic [ID_W-1:0]   dst0_id,
  input  logic [ID_W-1:0]   dst1_id,
  input  logic [DUSE_W-1:0] dst_use,
  input  logic [ID_W-1:0]   pred_id,
  input  logic [ID_W-1:0]   src0_id,
  input  logic [ID_W-1:0]   src1_id,
  input  logic [ID_W-1:0]   src2_id,
  input  logic [SUSE_W-1:0] src_use,
  input  logic [IDX_W-1:0]  entry_index,
  input  rdb_cmd_t          cmd,
  output rdb_status_t       status,
  output logic              done,
  output logic              dependent,
  output logic              entry_valid,
  output logic              buffer_empty,
  output logic              overflowed
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Captured request.
  logic [OPC_W-1:0]          op_q;
  logic [KEYS-1:0][ID_W-1:0] key_q;
  logic [KEYS-1:0]           use_q;
  logic [IDX_W-1:0]          idx_q;

  // Scan state.
  logic [AW-1:0]   scan_addr;
  logic            cmp_vld;
  logic [AW-1:0]   cmp_addr;
  logic [ID_W-1:0] rd_data;
  logic [KEYS-1:0] hit;
  logic [AW-1:0]   free1;
  logic [AW-1:0]   free2;
  logic            has_free1;
  logic            has_free2;
  logic            ins0_q;

  // Buffer state.
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] valid_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               ovf;
  logic               ovf_next;

  // Insert decisions.
  logic          w0, ins0, ovf0;
  logic          dup1, w1, slot_ok, ins1, ovf1;
  logic [AW-1:0] slot1;
  logic [AW-1:0] idx_a;
  logic          in_range;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ID_W-1:0] ram_wdata;

  // Status toward the controller.
  always_comb begin
    status.needs_scan = instr_valid &&
                        (((opcode == OP_ADD) && !ovf) || (opcode == OP_CHECK));
    status.scan_last  = (scan_addr == AW'(ENTRIES - 1));
    status.is_add     = (op_q == OP_ADD);
  end

  // Request capture; keys and usable bits depend on the operation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      idx_q <= entry_index;
      if (opcode == OP_ADD) begin
        key_q <= {src2_id, src1_id, dst1_id, dst0_id};
        use_q <= {2'b00, dst_use & DST_MASK};
      end else begin
        key_q <= {src2_id, src1_id, src0_id, pred_id};
        use_q <= src_use & SRC_MASK;
      end
    end
  end

  // Scan address counter and read-data qualifier.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_addr <= '0;
    end else if (cmd.scan_rd) begin
      scan_addr <= scan_addr + AW'(1);
    end
    if (cmd.scan_rd) begin
      cmp_addr <= scan_addr;
    end
  end

  // Compare each stored id against all keys and note the first two free slots.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit       <= '0;
      has_free1 <= 1'b0;
      has_free2 <= 1'b0;
    end else if (cmp_vld) begin
      if (valid[cmp_addr]) begin
        for (int k = 0; k < KEYS; k++) begin
          if (rd_data == key_q[k]) begin
            hit[k] <= 1'b1;
          end
        end
      end else if (!has_free1) begin
        free1     <= cmp_addr;
        has_free1 <= 1'b1;
      end else if (!has_free2) begin
        free2     <= cmp_addr;
        has_free2 <= 1'b1;
      end
    end
  end

  // First destination: skipped when present, else takes the first free slot or, with none free, sets overflow.
  assign w0   = use_q[0] && !ovf && !hit[0];
  assign ins0 = w0 && has_free1;
  assign ovf0 = w0 && !has_free1;

  always_ff @(posedge clk) begin
    if (cmd.commit0) begin
      ins0_q <= ins0;
    end
  end

  // Second destination: also a duplicate of a just-inserted first destination.
  assign dup1    = hit[1] || (ins0_q && (key_q[1] == key_q[0]));
  assign w1      = use_q[1] && !ovf && !dup1;
  assign slot_ok = ins0_q ? has_free2 : has_free1;
  assign slot1   = ins0_q ? free2 : free1;
  assign ins1    = w1 && slot_ok;
  assign ovf1    = w1 && !slot_ok;

  // Id store.
  assign ram_we    = (cmd.commit0 && ins0) || (cmd.commit1 && ins1);
  assign ram_waddr = cmd.commit0 ? free1 : slot1;
  assign ram_wdata = cmd.commit0 ? key_q[0] : key_q[1];

  rdb_ram #(
    .WIDTH (ID_W),
    .DEPTH (ENTRIES)
  ) u_ids (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_rd),
    .raddr (scan_addr),
    .rdata (rd_data)
  );

  assign idx_a    = AW'(idx_q);
  assign in_range = (int'(idx_q) < ENTRIES);

  // Next valid bits, entry count and overflow flag.
  always_comb begin
    valid_next = valid;
    count_next = count;
    ovf_next   = ovf;
    if (cmd.commit0) begin
      if (ins0) begin
        valid_next[free1] = 1'b1;
        count_next        = count + CW'(1);
      end
      if (ovf0) begin
        ovf_next = 1'b1;
      end
    end
    if (cmd.commit1) begin
      if (ins1) begin
        valid_next[slot1] = 1'b1;
        count_next        = count + CW'(1);
      end
      if (ovf1) begin
        ovf_next = 1'b1;
      end
    end
    if (cmd.finish) begin
      case (op_q)
        OP_CLEAR: begin
          if (in_range && valid[idx_a]) begin
            valid_next[idx_a] = 1'b0;
            count_next        = count - CW'(1);
          end
        end
        OP_FLUSH: begin
          valid_next = '0;
          count_next = '0;
          ovf_next   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      valid <= valid_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // Result registers, loaded in the finishing cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dependent    <= (op_q == OP_CHECK) && |(use_q & hit);
      entry_valid  <= (op_q == OP_QUERY) && in_range && valid[idx_a];
      buffer_empty <= (count_next == '0);
      overflowed   <= ovf_next;
    end
  end

endmodule

### rtl/rdb_checker.sv
// Port-level checker for the replay dependency buffer and its bind.
`timescale 1ns / 1ps

module rdb_port_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic dependent,
  input logic entry_valid,
  input logic buffer_empty,
  input logic overflowed
);

  // A result is shown only while the block is free for a new request.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Each request gives a single-cycle strobe.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // A dependency match needs a stored id.
  a_dep_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && dependent) |-> !buffer_empty)
    else $error("dependency reported on an empty buffer");

  // A valid queried entry means the buffer is not empty.
  a_query_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && entry_valid) |-> !buffer_empty)
    else $error("valid entry reported on an empty buffer");

endmodule

bind replay_dependency_buffer_top rdb_port_checker u_rdb_port_checker (.*);
